>>> sv/ssm_pkg.sv
`default_nettype none
package ssm_pkg;

   localparam int SIDE_DEPTH_DEF = 16;
   localparam int VALUE_W        = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic SIDE_A = 1'b0;
   localparam logic SIDE_B = 1'b1;

   // one accepted, useful input beat as seen by the back end
   typedef struct packed {
      logic                      side;
      logic signed [VALUE_W-1:0] value;
      logic                      carries;
      logic                      ends;
   } cmd_type;

   // queue head presented to the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_READ = 3'b010,
      B_PICK = 3'b100
   } back_state_type;

endpackage
`default_nettype wire

>>> sv/ssm_ram.sv
`default_nettype none
module ssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> sv/ssm_front.sv
`default_nettype none
module ssm_front
   import ssm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_side,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_carries_value,
   input  wire logic               req_end_of_side,
   input  wire logic               q_full,
   output logic                    q_push,
   output cmd_type                 q_cmd
);

   logic [1:0] ended_ff, ended_in;
   logic [1:0] ended_next;
   logic       accept;
   logic       useful;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   // drop beats for an ended side and beats that carry nothing
   assign useful    = !ended_ff[req_side] && (req_carries_value || req_end_of_side);
   assign q_push    = accept && useful;

   assign q_cmd.side    = req_side;
   assign q_cmd.value   = req_value;
   assign q_cmd.carries = req_carries_value;
   assign q_cmd.ends    = req_end_of_side;

   always_comb begin
      ended_next = ended_ff;
      ended_next[req_side] = 1'b1;
      ended_in = ended_ff;
      if (q_push && req_end_of_side) begin
         // both sides ended: the back end finishes this merge, start fresh
         ended_in = (&ended_next) ? 2'b00 : ended_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 2'b00;
      end else begin
         ended_ff <= ended_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/ssm_queue.sv
`default_nettype none
module ssm_queue
   import ssm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type wr_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_chan_type head
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   function automatic logic [QPTR_W-1:0] qinc(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? qinc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? qinc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/ssm_back.sv
`default_nettype none
module ssm_back
   import ssm_pkg::*;
#(
   parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_chan_type  head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic signed [31:0] rsp_merged_value,
   output logic               rsp_has_value,
   output logic               rsp_from_side,
   output logic               rsp_last,
   output logic               rsp_overflow
);

   localparam int PTR_W = $clog2(SIDE_DEPTH);
   localparam int CNT_W = $clog2(SIDE_DEPTH + 1);

   back_state_type             state_ff, state_in;
   logic [1:0][CNT_W-1:0]      cnt_ff, cnt_in;
   logic [1:0][PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [1:0][PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 ended_ff, ended_in;
   logic [1:0]                 wr_en;
   logic signed [VALUE_W-1:0]  head_a;
   logic signed [VALUE_W-1:0]  head_b;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic                       has_value_ff, has_value_in;
   logic                       from_side_ff, from_side_in;
   logic                       last_ff, last_in;
   logic                       overflow_ff, overflow_in;
   logic                       load;
   logic                       out_free;

   logic                       pick_valid;
   logic                       pick;
   logic                       final_pick;
   logic [CNT_W:0]             cnt_sum;

   function automatic logic [PTR_W-1:0] pinc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(SIDE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   ssm_ram #(.WIDTH(VALUE_W), .DEPTH(SIDE_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en[SIDE_A]),
      .wr_addr (wr_ptr_ff[SIDE_A]),
      .wr_data (head.cmd.value),
      .rd_addr (rd_ptr_ff[SIDE_A]),
      .rd_data (head_a)
   );

   ssm_ram #(.WIDTH(VALUE_W), .DEPTH(SIDE_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en[SIDE_B]),
      .wr_addr (wr_ptr_ff[SIDE_B]),
      .wr_data (head.cmd.value),
      .rd_addr (rd_ptr_ff[SIDE_B]),
      .rd_data (head_b)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_sum  = {1'b0, cnt_ff[SIDE_A]} + {1'b0, cnt_ff[SIDE_B]};

   // pick the smaller head; ties go to A; an empty open side blocks
   always_comb begin
      pick_valid = 1'b1;
      pick       = SIDE_A;
      if (cnt_ff[SIDE_A] != '0 && cnt_ff[SIDE_B] != '0) begin
         pick = (head_a <= head_b) ? SIDE_A : SIDE_B;
      end else if (cnt_ff[SIDE_A] != '0 && ended_ff[SIDE_B]) begin
         pick = SIDE_A;
      end else if (cnt_ff[SIDE_B] != '0 && ended_ff[SIDE_A]) begin
         pick = SIDE_B;
      end else begin
         pick_valid = 1'b0;
      end
      final_pick = (&ended_ff) && (cnt_sum == (CNT_W + 1)'(1));
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      ended_in     = ended_ff;
      wr_en        = 2'b00;
      q_pop        = 1'b0;
      load         = 1'b0;
      value_in     = '0;
      has_value_in = 1'b0;
      from_side_in = SIDE_A;
      last_in      = 1'b0;
      overflow_in  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (head.valid && out_free) begin
               q_pop = 1'b1;
               if (head.cmd.carries) begin
                  if (cnt_ff[head.cmd.side] == CNT_W'(SIDE_DEPTH)) begin
                     // side full: drop the value, flag it
                     load         = 1'b1;
                     from_side_in = head.cmd.side;
                     overflow_in  = 1'b1;
                  end else begin
                     wr_en[head.cmd.side]     = 1'b1;
                     cnt_in[head.cmd.side]    = cnt_ff[head.cmd.side] + CNT_W'(1);
                     wr_ptr_in[head.cmd.side] = pinc(wr_ptr_ff[head.cmd.side]);
                  end
               end
               if (head.cmd.ends) begin
                  ended_in[head.cmd.side] = 1'b1;
               end
               state_in = B_READ;
            end
         end
         B_READ: begin
            // wait for the registered head reads
            state_in = B_PICK;
         end
         B_PICK: begin
            if (pick_valid) begin
               if (out_free) begin
                  load              = 1'b1;
                  value_in          = (pick == SIDE_B) ? head_b : head_a;
                  has_value_in      = 1'b1;
                  from_side_in      = pick;
                  last_in           = final_pick;
                  cnt_in[pick]      = cnt_ff[pick] - CNT_W'(1);
                  rd_ptr_in[pick]   = pinc(rd_ptr_ff[pick]);
                  if (final_pick) begin
                     ended_in = 2'b00;
                     state_in = B_IDLE;
                  end else begin
                     state_in = B_READ;
                  end
               end
            end else if (&ended_ff) begin
               // both ended, nothing left: valueless last
               if (out_free) begin
                  load     = 1'b1;
                  last_in  = 1'b1;
                  ended_in = 2'b00;
                  state_in = B_IDLE;
               end
            end else begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      rsp_valid_in = out_free ? load : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff     <= value_in;
         has_value_ff <= has_value_in;
         from_side_ff <= from_side_in;
         last_ff      <= last_in;
         overflow_ff  <= overflow_in;
      end
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         ended_ff     <= 2'b00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = value_ff;
   assign rsp_has_value    = has_value_ff;
   assign rsp_from_side    = from_side_ff;
   assign rsp_last         = last_ff;
   assign rsp_overflow     = overflow_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[SIDE_A] <= CNT_W'(SIDE_DEPTH) && cnt_ff[SIDE_B] <= CNT_W'(SIDE_DEPTH))
      else $error("side count beyond depth");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !has_value_ff && !overflow_ff |-> last_ff)
      else $error("valueless beat without last");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      load && last_in |=> ended_ff == 2'b00 && state_ff == B_IDLE)
      else $error("merge not restarted after last");
`endif

endmodule
`default_nettype wire

>>> sv/sorted_stream_merge_unit.sv
// Path: an accepted beat reaches rsp_valid at the earliest through the queue, the RAM write,
//   the registered head read and the output register.
// Flow: the back end pops the next queued beat only from idle, after emitting every element
//   it can pick; req_stall rises once the 2-entry queue is full.
// Reset: synchronous, active high; clears counts, ended flags, queue and rsp_valid;
//   side RAM contents are left as is and are read only after being written.
`default_nettype none
module sorted_stream_merge_unit
   import ssm_pkg::*;
#(
   parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input beats
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_side,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_carries_value,
   input  wire logic               req_end_of_side,
   // result beats
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_merged_value,
   output logic                    rsp_has_value,
   output logic                    rsp_from_side,
   output logic                    rsp_last,
   output logic                    rsp_overflow
);

   // front -> queue
   logic         q_push;
   logic         q_full;
   cmd_type      q_cmd;
   // queue -> back
   cmd_chan_type q_head;
   logic         q_pop;

   // Front: accept beats, drop those for an ended side or carrying nothing,
   // and track the ended flags so a new merge starts right after both end.
   ssm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_side          (req_side),
      .req_value         (req_value),
      .req_carries_value (req_carries_value),
      .req_end_of_side   (req_end_of_side),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (q_cmd)
   );

   // Short command queue: hold classified beats while the back end drains.
   ssm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (q_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .head   (q_head)
   );

   // Back: push into the side RAMs, flag overflow, merge heads and emit
   // through the output register, marking the final beat of each merge.
   ssm_back #(.SIDE_DEPTH(SIDE_DEPTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_has_value    (rsp_has_value),
      .rsp_from_side    (rsp_from_side),
      .rsp_last         (rsp_last),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
`default_nettype wire
